// File: sv/trle_pkg.sv
// trle_pkg: sizes, emit selects and controller/datapath command and status types
// for the threshold run-length row encoder
// no dependencies
`default_nettype none

package trle_pkg;

  // row buffer sizing
  localparam int ROW_BYTES = 32;
  localparam int LIT_W     = $clog2(ROW_BYTES + 1);
  localparam int ADDR_W    = $clog2(ROW_BYTES);

  localparam int THR_W = 7;
  localparam logic [THR_W-1:0] THR_RESET = 7'd8;

  // what the datapath puts into the pending output slot
  localparam logic [1:0] SEL_RAW_HDR = 2'd0;
  localparam logic [1:0] SEL_RUN_HDR = 2'd1;
  localparam logic [1:0] SEL_RUN_VAL = 2'd2;
  localparam logic [1:0] SEL_LIT     = 2'd3;

  typedef struct packed {
    logic       load_in;
    logic       emit;
    logic [1:0] emit_sel;
    logic       rd_start;
    logic       append;
    logic       run_clear;
    logic       lit_clear;
    logic       run_inc;
    logic       run_start;
    logic       row_clear;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic run_zero;
    logic run_one;
    logic run_meets;
    logic lit_zero;
    logic lit_last;
    logic match;
    logic row_end;
    logic stall;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/trle_if.sv
// trle_if: valid/ready channel interfaces for input items, result items and
// the threshold write port; no dependencies
`default_nettype none

interface trle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       row_end;
  modport source (output valid, output data_byte, output row_end, input ready);
  modport sink (input valid, input data_byte, input row_end, output ready);
endinterface

interface trle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_burst;
  logic       row_done;
  modport source (output valid, output out_byte, output last_of_burst, output row_done,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_burst, input row_done,
                output ready);
endinterface

interface trle_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] run_threshold;
  modport source (output valid, output run_threshold, input ready);
  modport sink (input valid, input run_threshold, output ready);
endinterface

`default_nettype wire

// File: sv/trle_dp.sv
// trle_dp: datapath of the encoder - run/literal state, literal buffer memory,
// pending byte slot and output register; uses trle_pkg
`default_nettype none

module trle_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  trle_pkg::cmd_t       cmd,
  output trle_pkg::sts_t       sts,
  input  wire  [7:0]           in_data_byte,
  input  wire                  in_row_end,
  input  wire                  cfg_valid,
  input  wire  [6:0]           cfg_run_threshold,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last_of_burst,
  output logic                 out_row_done
);

  localparam int LW = trle_pkg::LIT_W;
  localparam int AW = trle_pkg::ADDR_W;

  logic [7:0]    mem [trle_pkg::ROW_BYTES];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic          wr_en;

  logic [7:0]    b_r;
  logic          e_r;
  logic [7:0]    rv_r, rv_nxt;
  logic [LW-1:0] run_r, run_nxt;
  logic [LW-1:0] lit_r, lit_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] idx_inc;
  logic [LW:0]   held_sum;
  logic [6:0]    thr_r;

  logic          pend_valid_r, pend_valid_nxt;
  logic [7:0]    pend_byte_r, pend_byte_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_last_r;
  logic          out_done_r;
  logic          push;
  logic [7:0]    emit_byte;
  logic [LW-1:0] lit_m1;
  logic [LW-1:0] run_m1;

  assign idx_inc  = idx_r + LW'(1);
  assign held_sum = {1'b0, lit_r} + {1'b0, run_r};
  assign lit_m1   = lit_r - LW'(1);
  assign run_m1   = run_r - LW'(1);

  // status back to the controller
  always_comb begin
    sts.full      = held_sum >= (LW+1)'(trle_pkg::ROW_BYTES);
    sts.run_zero  = run_r == '0;
    sts.run_one   = run_r == LW'(1);
    sts.run_meets = 7'(run_r) >= thr_r;
    sts.lit_zero  = lit_r == '0;
    sts.lit_last  = idx_inc == lit_r;
    sts.match     = (run_r != '0) && (b_r == rv_r);
    sts.row_end   = e_r;
    sts.stall     = pend_valid_r && out_valid_r && !out_ready;
  end

  always_comb begin
    case (cmd.emit_sel)
      trle_pkg::SEL_RAW_HDR: emit_byte = {1'b0, 7'(lit_m1)};
      trle_pkg::SEL_RUN_HDR: emit_byte = {1'b1, 7'(run_m1)};
      trle_pkg::SEL_RUN_VAL: emit_byte = rv_r;
      trle_pkg::SEL_LIT:     emit_byte = rd_data_r;
      default:               emit_byte = rd_data_r;
    endcase
  end

  // buffer ports
  assign wr_en   = cmd.append && (lit_r < LW'(trle_pkg::ROW_BYTES));
  assign rd_en   = cmd.rd_start || (cmd.emit && (cmd.emit_sel == trle_pkg::SEL_LIT));
  assign rd_addr = cmd.rd_start ? '0 : idx_inc[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[lit_r[AW-1:0]] <= rv_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // run / literal bookkeeping
  always_comb begin
    rv_nxt  = rv_r;
    run_nxt = run_r;
    lit_nxt = lit_r;
    idx_nxt = idx_r;
    if (cmd.append) begin
      run_nxt = run_m1;
      if (wr_en) begin
        lit_nxt = lit_r + LW'(1);
      end
    end
    if (cmd.run_inc) begin
      run_nxt = run_r + LW'(1);
    end
    if (cmd.run_start) begin
      rv_nxt  = b_r;
      run_nxt = LW'(1);
    end
    if (cmd.run_clear) begin
      run_nxt = '0;
    end
    if (cmd.rd_start) begin
      idx_nxt = '0;
    end
    if (cmd.emit && (cmd.emit_sel == trle_pkg::SEL_LIT)) begin
      idx_nxt = idx_inc;
      if (sts.lit_last) begin
        lit_nxt = '0;
      end
    end
    if (cmd.lit_clear) begin
      lit_nxt = '0;
    end
    if (cmd.row_clear) begin
      rv_nxt  = '0;
      run_nxt = '0;
      lit_nxt = '0;
    end
  end

  // pending slot and output register: a byte is shown only once the next one
  // exists or the item ends, so its last flag is known
  assign push = (cmd.emit || cmd.fin) && pend_valid_r;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      pend_valid_nxt = 1'b1;
      pend_byte_nxt  = emit_byte;
    end
    if (cmd.fin) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r         <= '0;
      run_r        <= '0;
      lit_r        <= '0;
      idx_r        <= '0;
      thr_r        <= trle_pkg::THR_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rv_r         <= rv_nxt;
      run_r        <= run_nxt;
      lit_r        <= lit_nxt;
      idx_r        <= idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid) begin
        thr_r <= cfg_run_threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    if (cmd.load_in) begin
      b_r <= in_data_byte;
      e_r <= in_row_end;
    end
    if (push) begin
      out_byte_r <= pend_byte_r;
      out_last_r <= cmd.fin;
      out_done_r <= cmd.fin && e_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_burst = out_last_r;
  assign out_row_done      = out_done_r;

endmodule

`default_nettype wire

// File: sv/trle_ctrl.sv
// trle_ctrl: sequencer of the encoder - walks the pre-flush, run update and
// row-end flush of one item; uses trle_pkg
`default_nettype none

module trle_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  trle_pkg::sts_t sts,
  output trle_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PRE      = 4'd1;
  localparam logic [3:0] S_CR       = 4'd2;
  localparam logic [3:0] S_APPEND   = 4'd3;
  localparam logic [3:0] S_FL       = 4'd4;
  localparam logic [3:0] S_FL_HDR   = 4'd5;
  localparam logic [3:0] S_FL_DATA  = 4'd6;
  localparam logic [3:0] S_RUN_HDR  = 4'd7;
  localparam logic [3:0] S_RUN_VAL  = 4'd8;
  localparam logic [3:0] S_STEP     = 4'd9;
  localparam logic [3:0] S_END      = 4'd10;
  localparam logic [3:0] S_FIN      = 4'd11;

  // which flush of the item is running
  localparam logic [1:0] PH_PRE  = 2'd0;
  localparam logic [1:0] PH_MAIN = 2'd1;
  localparam logic [1:0] PH_POST = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       fl_run_r, fl_run_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    fl_run_nxt = fl_run_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          phase_nxt   = PH_PRE;
          state_nxt   = S_PRE;
        end
      end
      S_PRE: begin
        state_nxt = sts.full ? S_CR : S_STEP;
      end
      // close the open run
      S_CR: begin
        if (sts.run_zero) begin
          case (phase_r)
            PH_MAIN: begin
              cmd.run_start = 1'b1;
              state_nxt     = S_END;
            end
            default: begin
              fl_run_nxt = 1'b0;
              state_nxt  = S_FL;
            end
          endcase
        end else if (sts.run_meets) begin
          fl_run_nxt = 1'b1;
          state_nxt  = S_FL;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        if (sts.run_one) begin
          state_nxt = S_CR;
        end
      end
      // flush pending literals
      S_FL: begin
        if (sts.lit_zero) begin
          if (fl_run_r) begin
            state_nxt = S_RUN_HDR;
          end else begin
            case (phase_r)
              PH_POST: begin
                cmd.row_clear = 1'b1;
                state_nxt     = S_FIN;
              end
              default: state_nxt = S_STEP;
            endcase
          end
        end else begin
          cmd.rd_start = 1'b1;
          state_nxt    = S_FL_HDR;
        end
      end
      S_FL_HDR: begin
        if (!sts.stall) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = trle_pkg::SEL_RAW_HDR;
          state_nxt    = S_FL_DATA;
        end
      end
      S_FL_DATA: begin
        if (!sts.stall) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = trle_pkg::SEL_LIT;
          if (sts.lit_last) begin
            state_nxt = S_FL;
          end
        end
      end
      S_RUN_HDR: begin
        if (!sts.stall) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = trle_pkg::SEL_RUN_HDR;
          state_nxt    = S_RUN_VAL;
        end
      end
      S_RUN_VAL: begin
        if (!sts.stall) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = trle_pkg::SEL_RUN_VAL;
          cmd.run_clear = 1'b1;
          state_nxt     = S_CR;
        end
      end
      S_STEP: begin
        phase_nxt = PH_MAIN;
        if (sts.match) begin
          cmd.run_inc = 1'b1;
          state_nxt   = S_END;
        end else begin
          state_nxt = S_CR;
        end
      end
      S_END: begin
        if (sts.row_end) begin
          phase_nxt = PH_POST;
          state_nxt = S_CR;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.stall) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_PRE;
      fl_run_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      fl_run_r <= fl_run_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/threshold_run_length_row_encoder.sv
// threshold_run_length_row_encoder: top level, joins the sequencer and the datapath
// depends on trle_pkg, trle_if, trle_ctrl, trle_dp
//
//  channel   dir   handshake          payload
//  in_ch     in    valid / ready      data_byte[7:0], row_end
//  out_ch    out   valid / ready      out_byte[7:0], last_of_burst, row_done
//  cfg_ch    in    valid / ready      run_threshold[6:0] (ready always high)
//
// one item at a time: a byte either extends the open run, opens the first run, or
// closes a short run by folding its bytes into the literal buffer; raw and run
// flushes emit their header and data bytes in turn. rst_n is synchronous, active
// low, and clears run, literal count and threshold (back to 8); the buffer
// needs no clearing. a stalled out_ch holds the sequencer at its next emit, and a
// new item is taken while the last result waits
`default_nettype none

module threshold_run_length_row_encoder (
  input wire          clk,
  input wire          rst_n,
  trle_in_if.sink     in_ch,
  trle_out_if.source  out_ch,
  trle_cfg_if.sink    cfg_ch
);

  trle_pkg::cmd_t cmd;
  trle_pkg::sts_t sts;
  logic           cfg_fire;

  // threshold is taken whenever offered
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  // sequencer: one item through pre-flush, run update and row-end flush
  trle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // state, literal buffer and output register
  trle_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_data_byte      (in_ch.data_byte),
    .in_row_end        (in_ch.row_end),
    .cfg_valid         (cfg_fire),
    .cfg_run_threshold (cfg_ch.run_threshold),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_byte          (out_ch.out_byte),
    .out_last_of_burst (out_ch.last_of_burst),
    .out_row_done      (out_ch.row_done)
  );

endmodule

`default_nettype wire
